>>> hw/rtl/multi_button_debounce_edge_latch_top_defines.svh
// Assertion macros for the button debouncer top level.
`ifndef MULTI_BUTTON_DEBOUNCE_EDGE_LATCH_TOP_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_EDGE_LATCH_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define MBDEL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define MBDEL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/mbdel_pkg.sv
// Shared types and constants of the button debouncer.
package mbdel_pkg;

	localparam int NUM_BUTTONS = 16;
	localparam int LEVEL_W     = 16;
	localparam int INDEX_W     = 4;
	localparam int LOCK_W      = 5;
	localparam int PRESCALE_W  = 8;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 1;

	localparam logic [LOCK_W-1:0]     LOCKOUT_RESET  = LOCK_W'(20);
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(9);

	typedef enum logic [1:0] {
		CMD_SCAN    = 2'd0,
		CMD_PUBLISH = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RESET   = 2'd3
	} cmd_t;

	localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TICKS   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_RELOAD = 1'b1;

	// Decoded strobes of an accepted word; prescaler tick.
	typedef struct packed {
		logic scan;
		logic publish;
		logic read;
		logic restore;
		logic tick;
	} lane_ctrl_t;

	// What one lane reports to the merging stage.
	typedef struct packed {
		logic press;
		logic edge_bit;
		logic latched;
	} lane_out_t;

endpackage

>>> hw/rtl/mbdel_lane.sv
// One debounce lane: level, lockout, pending and latched edge of a button.
module mbdel_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbdel_pkg::lane_ctrl_t           ctrl,
	input  logic                            level,
	input  logic                            read_sel,
	input  logic [mbdel_pkg::LOCK_W-1:0]    lockout_ticks,
	output mbdel_pkg::lane_out_t            result
);

	logic                         level_q, level_d;
	logic                         pend_q, pend_d;
	logic                         latch_q, latch_d;
	logic [mbdel_pkg::LOCK_W-1:0] lock_q, lock_d;
	logic                         press;

	always_comb begin
		level_d = level_q;
		pend_d  = pend_q;
		latch_d = latch_q;
		lock_d  = lock_q;
		press   = 1'b0;
		if (ctrl.scan) begin
			if (level != level_q) begin
				level_d = level;
				if (lock_q == '0) begin
					if (!level) begin
						lock_d = lockout_ticks;
					end else begin
						pend_d = 1'b1;
						press  = 1'b1;
					end
				end
			end else if (ctrl.tick && lock_q != '0) begin
				lock_d = lock_q - mbdel_pkg::LOCK_W'(1);
			end
		end
		if (ctrl.publish) begin
			latch_d = latch_q | pend_q;
			pend_d  = 1'b0;
		end
		if (ctrl.read && read_sel) begin
			latch_d = 1'b0;
		end
		if (ctrl.restore) begin
			level_d = 1'b0;
			pend_d  = 1'b0;
			latch_d = 1'b0;
			lock_d  = lockout_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			pend_q  <= 1'b0;
			latch_q <= 1'b0;
			lock_q  <= mbdel_pkg::LOCKOUT_RESET;
		end else begin
			level_q <= level_d;
			pend_q  <= pend_d;
			latch_q <= latch_d;
			lock_q  <= lock_d;
		end
	end

	assign result.press    = press;
	assign result.edge_bit = ctrl.read && read_sel && latch_q;
	assign result.latched  = latch_d;

endmodule

>>> hw/rtl/multi_button_debounce_edge_latch_top.sv
// The result word of an accepted input word is in the output register in the next cycle.
// Throughput: one word per cycle; all buttons are handled by parallel lanes in that cycle.
// The input stalls only while the output register holds a word the consumer has not taken.
// Reset (arst_n low) clears levels, edges, prescaler and flag, loads lockouts with 20,
// and restores the lockout_ticks and prescale_reload registers to 20 and 9.
`include "multi_button_debounce_edge_latch_top_defines.svh"

module multi_button_debounce_edge_latch_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input word channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           cmd,
	input  logic [mbdel_pkg::LEVEL_W-1:0]        pressed_bits,
	input  logic [mbdel_pkg::INDEX_W-1:0]        button_index,
	// Result word channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 edge_read,
	output logic                                 update_pending,
	output logic [mbdel_pkg::LEVEL_W-1:0]        latched_bits,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [mbdel_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbdel_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [mbdel_pkg::LOCK_W-1:0]     lockout_ticks_q;
	logic [mbdel_pkg::PRESCALE_W-1:0] prescale_reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_ticks_q   <= mbdel_pkg::LOCKOUT_RESET;
			prescale_reload_q <= mbdel_pkg::PRESCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbdel_pkg::REG_LOCKOUT_TICKS: begin
					lockout_ticks_q <= cfg_data[mbdel_pkg::LOCK_W-1:0];
				end
				mbdel_pkg::REG_PRESCALE_RELOAD: begin
					prescale_reload_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// A word is taken whenever the output register is empty or is drained in this cycle,
	// so the core never waits on its own result.
	logic in_acc;
	assign in_stall = out_valid && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Command decode. Every command strobe is qualified by acceptance, so an idle cycle
	// leaves all lane state untouched.
	mbdel_pkg::cmd_t       cmd_code;
	mbdel_pkg::lane_ctrl_t ctrl;
	assign cmd_code = mbdel_pkg::cmd_t'(cmd);

	// The shared prescaler decrements on each scan, reloading when it was zero. Lockouts
	// tick on scans where the value it lands on is zero.
	logic [mbdel_pkg::PRESCALE_W-1:0] prescale_q, prescale_d;

	always_comb begin
		ctrl = '0;
		unique case (cmd_code)
			mbdel_pkg::CMD_SCAN:    ctrl.scan    = in_acc;
			mbdel_pkg::CMD_PUBLISH: ctrl.publish = in_acc;
			mbdel_pkg::CMD_READ:    ctrl.read    = in_acc;
			mbdel_pkg::CMD_RESET:   ctrl.restore = in_acc;
			default: begin
			end
		endcase
		prescale_d = (prescale_q != '0) ? prescale_q - mbdel_pkg::PRESCALE_W'(1)
		                                : prescale_reload_q;
		ctrl.tick  = (prescale_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
		end else if (ctrl.scan) begin
			prescale_q <= prescale_d;
		end
	end

	// One lane per button. Buttons beyond the input width always see a released level,
	// and only buttons the index can reach can be read.
	mbdel_pkg::lane_out_t           lane_res [mbdel_pkg::NUM_BUTTONS];
	logic [mbdel_pkg::NUM_BUTTONS-1:0] press_vec;
	logic [mbdel_pkg::NUM_BUTTONS-1:0] edge_vec;
	logic [mbdel_pkg::NUM_BUTTONS-1:0] latched_vec;

	for (genvar i = 0; i < mbdel_pkg::NUM_BUTTONS; i++) begin : g_lane
		logic level;
		logic read_sel;
		if (i < mbdel_pkg::LEVEL_W) begin : g_visible
			assign level    = pressed_bits[i];
			assign read_sel = (button_index == mbdel_pkg::INDEX_W'(i));
		end else begin : g_hidden
			assign level    = 1'b0;
			assign read_sel = 1'b0;
		end

		mbdel_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.level        (level),
			.read_sel     (read_sel),
			.lockout_ticks(lockout_ticks_q),
			.result       (lane_res[i])
		);

		assign press_vec[i]   = lane_res[i].press;
		assign edge_vec[i]    = lane_res[i].edge_bit;
		assign latched_vec[i] = lane_res[i].latched;
	end

	// Merging stage: any new press raises the update flag, publish clears it, and the
	// read edge comes from the single selected lane.
	logic update_q, update_d;
	logic [mbdel_pkg::LEVEL_W-1:0] latched_view;

	always_comb begin
		update_d = update_q;
		if (ctrl.scan && (press_vec != '0)) begin
			update_d = 1'b1;
		end
		if (ctrl.publish) begin
			update_d = 1'b0;
		end
		latched_view = '0;
		for (int k = 0; k < mbdel_pkg::NUM_BUTTONS && k < mbdel_pkg::LEVEL_W; k++) begin
			latched_view[k] = latched_vec[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_q <= 1'b0;
		end else begin
			update_q <= update_d;
		end
	end

	// Output register. It loads on every accepted word and empties when the consumer
	// takes the word without refilling.
	logic                          out_valid_q;
	logic                          edge_q;
	logic                          flag_q;
	logic [mbdel_pkg::LEVEL_W-1:0] latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			edge_q    <= |edge_vec;
			flag_q    <= update_d;
			latched_q <= latched_view;
		end
	end

	assign out_valid      = out_valid_q;
	assign edge_read      = edge_q;
	assign update_pending = flag_q;
	assign latched_bits   = latched_q;

	// Every accepted word yields a result word in the next cycle.
	`MBDEL_ASSERT_NEXT(a_result_follows, in_acc, out_valid)
	// A publish word always reports a cleared update flag.
	`MBDEL_ASSERT_NEXT(a_publish_clears_flag, ctrl.publish, !update_pending)
	// Only a read word can report an edge.
	`MBDEL_ASSERT_NEXT(a_edge_only_on_read, in_acc && !ctrl.read, !edge_read)
	// The prescaler only moves on scan words.
	`MBDEL_ASSERT_NEXT(a_prescale_holds, !ctrl.scan, $stable(prescale_q))

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the multi-button debouncer with press-edge latch.
`timescale 1ns / 1ps

module tb_top;

	// One command word as it crosses the input channel.
	typedef struct packed {
		mbdel_pkg::cmd_t                 op;
		logic [mbdel_pkg::LEVEL_W-1:0]   levels;
		logic [mbdel_pkg::INDEX_W-1:0]   idx;
	} button_word_t;

	// One result word as it leaves the block.
	typedef struct packed {
		logic                          edge_read;
		logic                          update_pending;
		logic [mbdel_pkg::LEVEL_W-1:0] latched_bits;
	} button_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        cmd = mbdel_pkg::CMD_SCAN;
	logic [mbdel_pkg::LEVEL_W-1:0]     pressed_bits = '0;
	logic [mbdel_pkg::INDEX_W-1:0]     button_index = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              edge_read;
	logic                              update_pending;
	logic [mbdel_pkg::LEVEL_W-1:0]     latched_bits;
	logic                              cfg_we = 1'b0;
	logic [mbdel_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mbdel_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	multi_button_debounce_edge_latch_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.pressed_bits   (pressed_bits),
		.button_index   (button_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.edge_read      (edge_read),
		.update_pending (update_pending),
		.latched_bits   (latched_bits),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// Words waiting to be offered to the block, and the results owed by it.
	button_word_t   cmd_words[$];
	button_result_t due_results[$];

	// Our own copy of the debouncer state, advanced once per accepted word.
	logic [mbdel_pkg::LEVEL_W-1:0]    deb_level;
	logic [mbdel_pkg::LEVEL_W-1:0]    deb_pending;
	logic [mbdel_pkg::LEVEL_W-1:0]    deb_latched;
	logic [mbdel_pkg::LOCK_W-1:0]     deb_lock [mbdel_pkg::NUM_BUTTONS];
	logic [mbdel_pkg::PRESCALE_W-1:0] deb_prescale;
	logic                             deb_flag;
	// Our own copy of the two configuration registers.
	logic [mbdel_pkg::LOCK_W-1:0]     deb_ticks;
	logic [mbdel_pkg::PRESCALE_W-1:0] deb_reload;

	// Sender pacing, receiver stall pattern and bookkeeping.
	int     burst_left = 0;
	int     gap_left = 0;
	logic   hold_sender = 1'b0;
	int     stall_left = 0;
	int     stall_mode = 0;
	int     errors = 0;
	int     n_scan = 0, n_publish = 0, n_read = 0, n_restore = 0, n_edges = 0;
	int     n_writes = 0, n_settings = 0;
	logic [mbdel_pkg::LEVEL_W-1:0] held_levels = '0;

	// Random filler for fields a command does not use.
	function automatic logic [mbdel_pkg::LEVEL_W-1:0] rnd_levels();
		return mbdel_pkg::LEVEL_W'($urandom);
	endfunction

	function automatic logic [mbdel_pkg::INDEX_W-1:0] rnd_index();
		return mbdel_pkg::INDEX_W'($urandom);
	endfunction

	// Put every button back to released, clear its edges and reload its lockout.
	task automatic restore_buttons();
		deb_level   = '0;
		deb_pending = '0;
		deb_latched = '0;
		for (int i = 0; i < mbdel_pkg::NUM_BUTTONS; i++)
			deb_lock[i] = deb_ticks;
	endtask

	// Advance the debouncer state by one accepted word and form its result.
	task automatic step_buttons(input button_word_t w, output button_result_t r);
		logic tick;
		logic now;
		r.edge_read = 1'b0;
		case (w.op)
			mbdel_pkg::CMD_SCAN: begin
				// The prescaler moves first; lockouts only age when it lands on zero.
				if (deb_prescale != '0)
					deb_prescale = deb_prescale - mbdel_pkg::PRESCALE_W'(1);
				else
					deb_prescale = deb_reload;
				tick = (deb_prescale == '0);
				for (int i = 0; i < mbdel_pkg::NUM_BUTTONS; i++) begin
					now = w.levels[i];
					if (now != deb_level[i]) begin
						// A level change never ages the lockout in the same scan.
						deb_level[i] = now;
						if (deb_lock[i] == '0) begin
							if (!now) begin
								deb_lock[i] = deb_ticks;
							end else begin
								deb_pending[i] = 1'b1;
								deb_flag = 1'b1;
							end
						end
					end else if (tick && deb_lock[i] != '0) begin
						deb_lock[i] = deb_lock[i] - mbdel_pkg::LOCK_W'(1);
					end
				end
			end
			mbdel_pkg::CMD_PUBLISH: begin
				deb_latched = deb_latched | deb_pending;
				deb_pending = '0;
				deb_flag    = 1'b0;
			end
			mbdel_pkg::CMD_READ: begin
				r.edge_read = deb_latched[w.idx];
				deb_latched[w.idx] = 1'b0;
			end
			default: begin
				// The restore command leaves the prescaler and the flag alone.
				restore_buttons();
			end
		endcase
		r.update_pending = deb_flag;
		r.latched_bits   = deb_latched;
	endtask

	task automatic push_word(input mbdel_pkg::cmd_t op,
			input logic [mbdel_pkg::LEVEL_W-1:0] lv,
			input logic [mbdel_pkg::INDEX_W-1:0] ix);
		button_word_t w;
		w.op = op;
		w.levels = lv;
		w.idx = ix;
		cmd_words.push_back(w);
	endtask

	// Register write; the block is idle whenever this is called, so our copy
	// of the register can change right away.
	task automatic write_reg(input logic [mbdel_pkg::CFG_INDEX_W-1:0] idx,
			input logic [mbdel_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == mbdel_pkg::REG_LOCKOUT_TICKS)
			deb_ticks = data[mbdel_pkg::LOCK_W-1:0];
		else
			deb_reload = data;
		n_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every queued word is accepted and every result has arrived,
	// then let the pipeline settle.
	task automatic drain();
		while (cmd_words.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Random traffic that mostly looks like real buttons: levels that stay
	// put for a while and then change a bit or two, with occasional fully
	// random scans, publishes, reads and the rare restore.
	task automatic random_words(input int n);
		int sel;
		int pick;
		logic [mbdel_pkg::LEVEL_W-1:0] flip;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 199);
			if (sel < 150) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					flip = mbdel_pkg::LEVEL_W'($urandom);
				else if (pick < 3)
					flip = mbdel_pkg::LEVEL_W'($urandom & $urandom);
				else
					flip = mbdel_pkg::LEVEL_W'($urandom & $urandom & $urandom & $urandom
						& $urandom);
				held_levels = held_levels ^ flip;
				push_word(mbdel_pkg::CMD_SCAN, held_levels, rnd_index());
			end else if (sel < 166) begin
				push_word(mbdel_pkg::CMD_PUBLISH, rnd_levels(), rnd_index());
			end else if (sel < 182) begin
				push_word(mbdel_pkg::CMD_READ, rnd_levels(),
					mbdel_pkg::INDEX_W'($urandom_range(0, mbdel_pkg::NUM_BUTTONS - 1)));
			end else if (sel < 198) begin
				push_word(mbdel_pkg::CMD_SCAN, held_levels, rnd_index());
			end else begin
				push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
			end
		end
	endtask

	// Driver: offers words from the queue in bursts with random gaps, and
	// advances our copy of the state on every word the block takes.
	always @(posedge clk) begin : drive
		button_word_t   w;
		button_result_t r;
		button_word_t   shown;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			shown.op     = mbdel_pkg::cmd_t'(cmd);
			shown.levels = pressed_bits;
			shown.idx    = button_index;
			if (in_valid && !in_stall) begin
				step_buttons(shown, r);
				due_results.push_back(r);
				case (shown.op)
					mbdel_pkg::CMD_SCAN:    n_scan++;
					mbdel_pkg::CMD_PUBLISH: n_publish++;
					mbdel_pkg::CMD_READ:    n_read++;
					default:                n_restore++;
				endcase
				if (r.edge_read)
					n_edges++;
			end
			// A stalled word stays on the bus untouched until it is taken.
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (hold_sender || cmd_words.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					w = cmd_words.pop_front();
					cmd          <= w.op;
					pressed_bits <= w.levels;
					button_index <= w.idx;
					in_valid     <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Monitor: checks every taken result word against the oldest one owed,
	// and stalls the result channel on a pattern that changes mode now and
	// then (never, light, heavy, alternating).
	always @(posedge clk) begin : watch
		button_result_t want;
		logic s;
		s = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result word with none expected: edge_read %0d, "
						, $time, edge_read, "update_pending %0d, latched_bits %h",
						update_pending, latched_bits);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (edge_read !== want.edge_read) begin
						$display("%0t: edge_read mismatch, expected %0d, got %0d",
							$time, want.edge_read, edge_read);
						errors++;
					end
					if (update_pending !== want.update_pending) begin
						$display("%0t: update_pending mismatch, expected %0d, got %0d",
							$time, want.update_pending, update_pending);
						errors++;
					end
					if (latched_bits !== want.latched_bits) begin
						$display("%0t: latched_bits mismatch, expected %h, got %h",
							$time, want.latched_bits, latched_bits);
						errors++;
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(8, 60);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0:       s = 1'b0;
				1:       s = ($urandom_range(0, 3) == 0);
				2:       s = ($urandom_range(0, 3) != 0);
				default: s = ~out_stall;
			endcase
		end
		out_stall <= s;
	end

	// Main sequence: reset, a directed part under three settings, then random
	// phases across a range of settings, including both extremes.
	initial begin
		logic [mbdel_pkg::LOCK_W-1:0]     ticks_set [8];
		logic [mbdel_pkg::PRESCALE_W-1:0] reload_set [8];
		int                               words_set [8];
		logic [mbdel_pkg::CFG_DATA_W-1:0] lock_data;

		ticks_set  = '{5'd0, 5'd2, 5'd5, 5'd31, 5'd3, 5'd20, 5'd31, 5'd0};
		reload_set = '{8'd0, 8'd1, 8'd3, 8'd0, 8'd255, 8'd9, 8'd255, 8'd0};
		words_set  = '{200, 200, 200, 180, 150, 200, 60, 240};
		// The last phase draws its setting at random.
		ticks_set[7]  = mbdel_pkg::LOCK_W'($urandom_range(0, 31));
		reload_set[7] = mbdel_pkg::PRESCALE_W'($urandom_range(0, 15));

		deb_ticks    = mbdel_pkg::LOCKOUT_RESET;
		deb_reload   = mbdel_pkg::PRESCALE_RESET;
		deb_prescale = '0;
		deb_flag     = 1'b0;
		restore_buttons();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset every lockout is loaded with 20, so level changes register
		// nothing; publishing with no flag set still clears cleanly.
		n_settings++;
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd0);
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		push_word(mbdel_pkg::CMD_PUBLISH, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'h0000, rnd_index());
		push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
		drain();

		// No lockout and a prescaler that ticks on every scan: every press
		// counts at once.
		write_reg(mbdel_pkg::REG_LOCKOUT_TICKS, 8'd0);
		write_reg(mbdel_pkg::REG_PRESCALE_RELOAD, 8'd0);
		n_settings++;
		push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd15);
		push_word(mbdel_pkg::CMD_PUBLISH, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd0);
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd15);
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd15);
		push_word(mbdel_pkg::CMD_SCAN, 16'h0000, rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hA5A5, rnd_index());
		// A restore while the flag is up leaves the flag set, so the next
		// publish finds the flag with nothing pending.
		push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_PUBLISH, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'h5A5A, rnd_index());
		push_word(mbdel_pkg::CMD_PUBLISH, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_READ, rnd_levels(), 4'd6);
		drain();

		// A one-tick lockout: the press right after a level change is
		// ignored, and a stable scan is needed before the next one counts.
		write_reg(mbdel_pkg::REG_LOCKOUT_TICKS, 8'd1);
		n_settings++;
		push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'h0000, rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		push_word(mbdel_pkg::CMD_SCAN, 16'hFFFF, rnd_index());
		drain();

		for (int p = 0; p < 8; p++) begin
			// The lockout register keeps only its low bits; set the upper
			// data bits now and then to be sure they are dropped.
			lock_data = {3'($urandom_range(0, 7)), ticks_set[p]};
			if ($urandom_range(0, 1) == 0)
				lock_data[mbdel_pkg::CFG_DATA_W-1:mbdel_pkg::LOCK_W] = '0;
			write_reg(mbdel_pkg::REG_LOCKOUT_TICKS, lock_data);
			write_reg(mbdel_pkg::REG_PRESCALE_RELOAD, reload_set[p]);
			n_settings++;
			push_word(mbdel_pkg::CMD_RESET, rnd_levels(), rnd_index());
			random_words(words_set[p]);
			if (p == 2) begin
				// Hold the sender mid-phase until the block has nothing owed.
				while (cmd_words.size() > words_set[p] / 2)
					@(negedge clk);
				hold_sender = 1'b1;
				while (in_valid || due_results.size() != 0)
					@(negedge clk);
				repeat (10) @(negedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		repeat (5) @(negedge clk);
		$display("Covered %0d words: %0d scans, %0d publishes, %0d reads",
			n_scan + n_publish + n_read + n_restore, n_scan, n_publish, n_read,
			" (%0d found an edge), %0d restores.", n_edges, n_restore);
		$display("Wrote registers %0d times across %0d settings, from zero to full scale.",
			n_writes, n_settings);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mbdel_pkg.sv
hw/rtl/mbdel_lane.sv
hw/rtl/multi_button_debounce_edge_latch_top.sv
test/tb_top.sv
